>>> sv/cfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfm_pkg;

    // register widths
    localparam int SpcW  = 16;
    localparam int DimW  = 13;
    localparam int HalfW = DimW - 1;
    localparam int ColW  = 12;
    localparam int RowW  = 12;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    localparam int DefSampleBits = 16;
    localparam int DefMaxDim     = 4096;
    localparam int DefQueueDepth = 4;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SPC    = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_TOTAL  = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg_idx;

    localparam logic [SpcW-1:0] SpcReset    = 16'd1;
    localparam logic [DimW-1:0] HeightReset = 13'd200;
    localparam logic [DimW-1:0] TotalReset  = 13'd800;

    // effective configuration, already clamped
    typedef struct packed {
        logic [SpcW-1:0]  spc;
        logic [HalfW-1:0] half;
        logic [DimW-1:0]  total;
    } t_cfg;

endpackage

`default_nettype wire

>>> sv/minmax_column_envelope.sv
// Min/max column envelope for waveform display.
// s_axis carries signed audio samples (tdata) with tlast on the final sample
// of the stream. Samples fold, samples_per_column at a time, into columns; the
// min and max of each column (both seeded with zero) are mapped to pixel rows
// half + trunc(v * half / 2^(SAMPLE_BITS-1)), half = height / 2.
// m_axis gives one item per completed column: column, row_low, row_high, with
// tlast on the final column (on final sample or when column_total is reached).
// After the final column every input item is taken and dropped until reset.
// Configuration: cfg channel, index 0 samples_per_column, 1 image_height,
// 2 column_total; always ready, write only while the block is idle.
// Throughput: one sample per cycle while the queue is not full. The item of a
// closing column passes the queue write, then the multiply stage, then the
// output register before m_axis_tvalid rises.
// A 4-entry queue sits between the accumulator and the row mapping, so the
// input keeps flowing while the output is stalled until the queue fills;
// then s_axis_tready drops. Reset (i_rst_n low, synchronous) restores the
// register defaults 1 / 200 / 800 and clears all column state.
`timescale 1ns / 1ps
`default_nettype none

module minmax_column_envelope
    import cfm_pkg::*;
#(
    parameter int SAMPLE_BITS = DefSampleBits,
    parameter int MAX_DIM     = DefMaxDim
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // tdata: sample
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  wire logic                                s_axis_tvalid,
    input  wire logic                                s_axis_tlast,
    output logic                                     s_axis_tready,
    // tdata: column [11:0], row_low [23:12], row_high [35:24], zero pad
    output logic [39:0]                              m_axis_tdata,
    output logic                                     m_axis_tvalid,
    output logic                                     m_axis_tlast,
    input  wire logic                                m_axis_tready,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]                  i_cfg_index,
    input  wire logic [CfgDataW-1:0]                 i_cfg_data
);

    localparam int QW     = ColW + 2 * SAMPLE_BITS + 1;
    localparam int DimCap = (MAX_DIM < (1 << DimW) - 1) ? MAX_DIM : (1 << DimW) - 1;

    logic [SpcW-1:0] r_spc;
    logic [DimW-1:0] r_height, r_total;
    logic [DimW-1:0] h_sat, t_sat;
    t_cfg            cfg;

    logic            push, q_full, q_valid, pop;
    logic [QW-1:0]   push_data, q_data;
    logic [ColW-1:0] out_col;
    logic [RowW-1:0] out_lo, out_hi;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spc    <= SpcReset;
            r_height <= HeightReset;
            r_total  <= TotalReset;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SPC:    r_spc    <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data[DimW-1:0];
                CFG_TOTAL:  r_total  <= i_cfg_data[DimW-1:0];
                default:    ;
            endcase
        end
    end

    assign h_sat = (r_height > DimW'(DimCap)) ? DimW'(DimCap) : r_height;
    assign t_sat = (r_total > DimW'(DimCap)) ? DimW'(DimCap) : r_total;

    assign cfg.spc   = (r_spc == '0) ? SpcW'(1) : r_spc;
    assign cfg.half  = h_sat[DimW-1:1];
    assign cfg.total = (t_sat == '0) ? DimW'(1) : t_sat;

    cfm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .QW          (QW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (s_axis_tvalid),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_final     (s_axis_tlast),
        .i_q_full    (q_full),
        .o_ready     (s_axis_tready),
        .o_push      (push),
        .o_push_data (push_data)
    );

    cfm_queue #(
        .W     (QW),
        .DEPTH (DefQueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    cfm_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .QW          (QW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_half      (cfg.half),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_pop       (pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_column    (out_col),
        .o_row_low   (out_lo),
        .o_row_high  (out_hi),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, out_hi, out_lo, out_col};

endmodule

`default_nettype wire

>>> sv/cfm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cfm_front
    import cfm_pkg::*;
#(
    parameter int SAMPLE_BITS = DefSampleBits,
    parameter int QW          = ColW + 2 * SAMPLE_BITS + 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_valid,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_final,
    input  wire logic                   i_q_full,
    output logic                        o_ready,
    output logic                        o_push,
    output logic [QW-1:0]               o_push_data
);

    logic [SpcW-1:0]          r_fill;
    logic [DimW-1:0]          r_col;
    logic signed [SAMPLE_BITS-1:0] r_min, r_max;
    logic                     r_finished;

    logic signed [SAMPLE_BITS-1:0] s_val, n_min, n_max;
    logic [SpcW:0]            fill_inc;
    logic [DimW:0]            col_inc;
    logic                     accept, active, close, last;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign active   = !r_finished && (r_col < i_cfg.total);
    assign s_val    = i_sample;
    assign n_min    = (s_val < r_min) ? s_val : r_min;
    assign n_max    = (s_val > r_max) ? s_val : r_max;
    assign fill_inc = {1'b0, r_fill} + 1'b1;
    assign col_inc  = {1'b0, r_col} + 1'b1;
    assign close    = (fill_inc >= {1'b0, i_cfg.spc}) || i_final;
    assign last     = i_final || (col_inc >= {1'b0, i_cfg.total});

    assign o_push      = accept && active && close;
    assign o_push_data = {last, n_max, n_min, r_col[ColW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_col      <= '0;
            r_min      <= '0;
            r_max      <= '0;
            r_finished <= 1'b0;
        end else if (accept && active) begin
            if (close) begin
                r_fill     <= '0;
                r_min      <= '0;
                r_max      <= '0;
                r_col      <= col_inc[DimW-1:0];
                r_finished <= last;
            end else begin
                r_fill <= fill_inc[SpcW-1:0];
                r_min  <= n_min;
                r_max  <= n_max;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/cfm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cfm_queue
    import cfm_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = DefQueueDepth
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic              o_full,
    output logic [W-1:0]      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (AW + 1)'(DEPTH));
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/cfm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cfm_back
    import cfm_pkg::*;
#(
    parameter int SAMPLE_BITS = DefSampleBits,
    parameter int QW          = ColW + 2 * SAMPLE_BITS + 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [HalfW-1:0] i_half,
    input  wire logic             i_q_valid,
    input  wire logic [QW-1:0]    i_q_data,
    output logic                  o_pop,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic [ColW-1:0]       o_column,
    output logic [RowW-1:0]       o_row_low,
    output logic [RowW-1:0]       o_row_high,
    output logic                  o_last
);

    localparam int PW = SAMPLE_BITS + HalfW + 1;
    localparam int SH = SAMPLE_BITS - 1;

    logic signed [SAMPLE_BITS-1:0] q_min, q_max;
    logic [ColW-1:0]  q_col;
    logic             q_last;

    // stage 1: products
    logic                 r_s1_valid, n_s1_valid;
    logic signed [PW-1:0] r_p_lo, r_p_hi;
    logic [ColW-1:0]      r_s1_col;
    logic                 r_s1_last;
    logic [HalfW-1:0]     r_s1_half;

    logic                 r_out_valid, n_out_valid;
    logic                 out_free, s1_free;
    logic signed [HalfW:0] half_s;
    logic signed [PW-1:0] row_lo, row_hi;

    assign {q_last, q_max, q_min, q_col} = i_q_data;

    assign out_free = !r_out_valid || i_out_ready;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_pop    = i_q_valid && s1_free;
    assign half_s   = {1'b0, i_half};

    assign n_s1_valid  = o_pop || (r_s1_valid && !out_free);
    assign n_out_valid = (r_s1_valid && out_free) || (r_out_valid && !i_out_ready);

    // row = half + trunc(p / 2^SH), truncation toward zero
    function automatic logic signed [PW-1:0] to_row(input logic signed [PW-1:0] p,
                                                     input logic [HalfW-1:0] h);
        logic signed [PW-1:0] bias;
        logic signed [PW-1:0] q;
        bias = p[PW-1] ? PW'((64'd1 << SH) - 64'd1) : '0;
        q    = (p + bias) >>> SH;
        return q + $signed(PW'(h));
    endfunction

    assign row_lo = to_row(r_p_lo, r_s1_half);
    assign row_hi = to_row(r_p_hi, r_s1_half);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_lo    <= PW'(q_min * half_s);
            r_p_hi    <= PW'(q_max * half_s);
            r_s1_col  <= q_col;
            r_s1_last <= q_last;
            r_s1_half <= i_half;
        end
        if (r_s1_valid && out_free) begin
            o_column   <= r_s1_col;
            o_row_low  <= row_lo[RowW-1:0];
            o_row_high <= row_hi[RowW-1:0];
            o_last     <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> test/tb_minmax_column_envelope.sv
`timescale 1ns / 1ps

module tb_minmax_column_envelope;
    import cfm_pkg::*;

    localparam int IdleLimit = 5000;
    localparam int SettleCyc = 8;
    localparam int HoldCyc   = 300;
    localparam int PhaseLen  = 185;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               fin;
    } t_sample_item;

    typedef struct packed {
        logic [ColW-1:0] column;
        logic [RowW-1:0] row_low;
        logic [RowW-1:0] row_high;
        logic            last;
    } t_column_span;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic [15:0] s_axis_tdata   = '0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tlast   = 1'b0;
    logic        s_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tlast;
    logic        m_axis_tready  = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index    = CFG_NONE;
    logic [15:0] i_cfg_data     = '0;

    minmax_column_envelope u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // envelope model state
    logic [SpcW-1:0] cfg_spc    = SpcReset;
    logic [DimW-1:0] cfg_height = HeightReset;
    logic [DimW-1:0] cfg_total  = TotalReset;
    int              fill       = 0;
    int              col_idx    = 0;
    int              run_min    = 0;
    int              run_max    = 0;
    bit              stream_done = 1'b0;

    t_sample_item pending_samples[$];
    t_column_span expected_columns[$];
    t_sample_item offered;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int fail_count     = 0;
    int idle_cycles    = 0;

    function automatic logic [RowW-1:0] pixel_row(int value, int height);
        longint half;
        longint prod;
        longint quot;
        half = height / 2;
        prod = value * half;
        // truncate toward zero
        if (prod < 0)
            quot = -((-prod) >>> (DefSampleBits - 1));
        else
            quot = prod >>> (DefSampleBits - 1);
        return RowW'(half + quot);
    endfunction

    task automatic fold_sample(input t_sample_item it);
        int           spc;
        int           h;
        int           tot;
        int           v;
        t_column_span res;
        spc = (cfg_spc == 0) ? 1 : int'(cfg_spc);
        h   = (cfg_height > DefMaxDim) ? DefMaxDim : int'(cfg_height);
        tot = (cfg_total > DefMaxDim) ? DefMaxDim : int'(cfg_total);
        if (tot == 0)
            tot = 1;
        if (stream_done || col_idx >= tot)
            return;
        v = $signed(it.sample);
        if (v < run_min)
            run_min = v;
        if (v > run_max)
            run_max = v;
        fill++;
        // a shrunk column size closes the column on the next item
        if (fill < spc && !it.fin)
            return;
        res.column   = col_idx[ColW-1:0];
        res.row_low  = pixel_row(run_min, h);
        res.row_high = pixel_row(run_max, h);
        res.last     = it.fin || (col_idx + 1 >= tot);
        expected_columns.push_back(res);
        fill    = 0;
        run_min = 0;
        run_max = 0;
        col_idx++;
        if (res.last)
            stream_done = 1'b1;
    endtask

    function automatic logic [15:0] rand_sample();
        int mag;
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: begin
                mag = $urandom_range(0, 400);
                return 16'($urandom_range(0, 1) ? mag : -mag);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic [15:0] s, input logic fin);
        t_sample_item it;
        it.sample = s;
        it.fin    = fin;
        pending_samples.push_back(it);
    endtask

    // wait for every item to be taken and every column to come back
    task automatic drain();
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_columns.size() != 0)
            @(negedge i_clk);
        repeat (SettleCyc) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        drain();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SPC:    cfg_spc    = val;
            CFG_HEIGHT: cfg_height = val[DimW-1:0];
            CFG_TOTAL:  cfg_total  = val[DimW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // sample driver
    always @(posedge i_clk) begin
        t_sample_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                fold_sample(offered);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_samples.pop_front();
                    offered       <= nxt;
                    s_axis_tdata  <= nxt.sample;
                    s_axis_tlast  <= nxt.fin;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // column monitor
    always @(posedge i_clk) begin
        t_column_span got;
        t_column_span want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.column   = m_axis_tdata[11:0];
                got.row_low  = m_axis_tdata[23:12];
                got.row_high = m_axis_tdata[35:24];
                got.last     = m_axis_tlast;
                if (expected_columns.size() == 0) begin
                    $display({"%0t: unexpected column: expected none,",
                              " actual col %0d lo %0d hi %0d last %0b"},
                             $time, got.column, got.row_low, got.row_high, got.last);
                    fail_count++;
                end else begin
                    want = expected_columns.pop_front();
                    if (got.column !== want.column || got.row_low !== want.row_low ||
                        got.row_high !== want.row_high || got.last !== want.last) begin
                        $display({"%0t: column mismatch: expected col %0d lo %0d hi %0d",
                                  " last %0b, actual col %0d lo %0d hi %0d last %0b"},
                                 $time, want.column, want.row_low, want.row_high,
                                 want.last, got.column, got.row_low, got.row_high,
                                 got.last);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left     <= hold_left - 1;
            end else if (hold_served != hold_asked) begin
                hold_served   <= hold_asked;
                hold_left     <= HoldCyc;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int          p;
        int          n;
        logic [15:0] spc_val;
        logic [15:0] h_val;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: one sample per column, height 200
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0001, 1'b0);
        push_sample(16'hFFFF, 1'b0);

        // full scale height, oversized column total saturates
        write_reg(CFG_SPC, 16'd4);
        write_reg(CFG_HEIGHT, 16'd4096);
        write_reg(CFG_TOTAL, 16'hFFFF);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h0005, 1'b0);
        push_sample(16'hFFFB, 1'b0);
        // all positive: minimum stays on the center line
        for (n = 1; n <= 4; n++)
            push_sample(16'(n), 1'b0);
        for (n = 1; n <= 4; n++)
            push_sample(16'(-n), 1'b0);

        // zero column size acts as one; degenerate heights map to row 0
        write_reg(CFG_SPC, 16'd0);
        write_reg(CFG_HEIGHT, 16'd1);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        write_reg(CFG_HEIGHT, 16'd0);
        push_sample(16'h8000, 1'b0);
        write_reg(CFG_HEIGHT, 16'd3);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);

        // huge column left open, then shrunk below its fill
        write_reg(CFG_SPC, 16'hFFFF);
        write_reg(CFG_HEIGHT, 16'd8191);
        push_sample(16'h1234, 1'b0);
        push_sample(16'hC000, 1'b0);
        push_sample(16'h4000, 1'b0);
        write_reg(CFG_SPC, 16'd2);
        push_sample(16'h0007, 1'b0);

        for (p = 0; p < 8; p++) begin
            case ($urandom_range(0, 9))
                0: spc_val = 16'd0;
                1: spc_val = 16'd1;
                2: spc_val = 16'($urandom_range(9, 40));
                default: spc_val = 16'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 7))
                0: h_val = 16'd1;
                1: h_val = 16'd2;
                2: h_val = 16'd4096;
                3: h_val = 16'($urandom_range(4097, 8191));
                default: h_val = 16'($urandom_range(3, 4095));
            endcase
            write_reg(CFG_SPC, spc_val);
            write_reg(CFG_HEIGHT, h_val);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            // long output stall while samples keep coming
            if (p == 4) begin
                write_reg(CFG_SPC, 16'd1);
                hold_asked++;
            end
            repeat (PhaseLen) push_sample(rand_sample(), 1'b0);

            // column total below the current index: everything is dropped
            if (p == 5) begin
                write_reg(CFG_TOTAL, 16'd1);
                repeat (12) push_sample(rand_sample(), 1'($urandom_range(0, 1)));
                push_sample(rand_sample(), 1'b1);
                write_reg(CFG_TOTAL, 16'd0);
                repeat (6) push_sample(rand_sample(), 1'($urandom_range(0, 1)));
                write_reg(CFG_TOTAL, 16'd4096);
            end
        end

        // close the stream: either the column total or the final sample ends it
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        spc_val = 16'($urandom_range(2, 6));
        write_reg(CFG_SPC, spc_val);
        write_reg(CFG_TOTAL, 16'(col_idx + 3));
        repeat (2 * spc_val) push_sample(rand_sample(), 1'b0);
        if ($urandom_range(0, 1)) begin
            repeat (spc_val) push_sample(rand_sample(), 1'b0);
        end else begin
            repeat ($urandom_range(0, spc_val - 2)) push_sample(rand_sample(), 1'b0);
            push_sample(rand_sample(), 1'b1);
        end
        repeat (20) push_sample(rand_sample(), 1'($urandom_range(0, 1)));

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
